[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks shared by the clusterer RTL; reset masks them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define QCC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define QCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/qcc_pkg.sv]
// ---------------------------------------------------------------------------
// Quarter-core clusterer package
// Field widths, queue entry types and the pixel geometry helpers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package qcc_pkg;

  localparam int HIT_W     = 16;
  localparam int HIT_IDX_W = $clog2(HIT_W);
  localparam int COL_W     = 6;
  localparam int ROW_W     = 8;
  localparam int NUM_SLOTS = 6;   // two merged, two half-0, two half-1
  localparam int QCC_QUEUE_DEPTH = 2;

  // Configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic REG_IDX_GEOMETRY = 1'b0;

  typedef struct packed {
    logic prev_column;
    logic next_column;
    logic prev_row;
    logic next_row;
  } touch_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0][HIT_W-1:0] mask;
    logic [NUM_SLOTS-1:0]            vld;
    logic [COL_W-1:0]                column;
    logic [ROW_W-1:0]                row;
    touch_t                          touch;
    logic                            last_flag;
    logic                            neighbour_flag;
    logic                            event_end_flag;
  } entry_t;

  typedef struct packed {
    logic full;
    logic has_data;
  } q_status_t;

  // Bit index of pixel (c, r); mode 1 is 4 rows per column, mode 0 is 2
  function automatic logic [HIT_IDX_W-1:0] pix_bit(int c, int r, logic mode);
    return HIT_IDX_W'(mode ? (c * 4 + r) : (c * 2 + r));
  endfunction

  function automatic int sub_cbase(int k, logic mode);
    return mode ? ((k & 1) * 2) : (k * 2);
  endfunction

  function automatic int sub_rbase(int k, logic mode);
    return mode ? ((k >> 1) * 2) : 0;
  endfunction

  // Two vertically stacked pixels of column c from row rb
  function automatic logic [HIT_W-1:0] col_bits(int c, int rb, logic mode);
    logic [HIT_W-1:0] res;
    res = '0;
    res[pix_bit(c, rb, mode)]     = 1'b1;
    res[pix_bit(c, rb + 1, mode)] = 1'b1;
    return res;
  endfunction

  // All four pixels of 2x2 sub-core k
  function automatic logic [HIT_W-1:0] sub_bits(int k, logic mode);
    return col_bits(sub_cbase(k, mode), sub_rbase(k, mode), mode) |
           col_bits(sub_cbase(k, mode) + 1, sub_rbase(k, mode), mode);
  endfunction

  // Facing columns of the two sub-cores in half h
  function automatic logic [HIT_W-1:0] face_lo(int h, logic mode);
    return col_bits(sub_cbase(2 * h, mode) + 1, sub_rbase(2 * h, mode), mode);
  endfunction

  function automatic logic [HIT_W-1:0] face_hi(int h, logic mode);
    return col_bits(sub_cbase(2 * h + 1, mode), sub_rbase(2 * h + 1, mode), mode);
  endfunction

  // Grow a mask by its 8-neighbourhood
  function automatic logic [HIT_W-1:0] dilate(logic [HIT_W-1:0] mask, logic mode);
    logic [HIT_W-1:0] res;
    int ci, ri, cj, rj;
    res = '0;
    for (int j = 0; j < HIT_W; j++) begin
      for (int i = 0; i < HIT_W; i++) begin
        ci = mode ? (i >> 2) : (i >> 1);
        ri = mode ? (i & 3) : (i & 1);
        cj = mode ? (j >> 2) : (j >> 1);
        rj = mode ? (j & 3) : (j & 1);
        if ((ci - cj >= -1) && (ci - cj <= 1) && (ri - rj >= -1) && (ri - rj <= 1)) begin
          res[j] = res[j] | mask[i];
        end
      end
    end
    return res;
  endfunction

endpackage

[rtl/core/qcc_if.sv]
// ---------------------------------------------------------------------------
// Clusterer channels
// Valid/ready interfaces for the hit-mask input and the cluster output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface qcc_in_if;
  import qcc_pkg::*;

  logic             valid;
  logic             ready;
  logic [HIT_W-1:0] hit_mask;
  logic [COL_W-1:0] core_column;
  logic [ROW_W-1:0] core_row;
  logic             last_flag;
  logic             neighbour_flag;
  logic             event_end_flag;

  modport source (
    output valid, hit_mask, core_column, core_row, last_flag, neighbour_flag,
           event_end_flag,
    input  ready
  );

  modport sink (
    input  valid, hit_mask, core_column, core_row, last_flag, neighbour_flag,
           event_end_flag,
    output ready
  );
endinterface

interface qcc_out_if;
  import qcc_pkg::*;

  logic             valid;
  logic             ready;
  logic [HIT_W-1:0] cluster_mask;
  logic [COL_W-1:0] out_column;
  logic [ROW_W-1:0] out_row;
  logic             touch_prev_column;
  logic             touch_next_column;
  logic             touch_prev_row;
  logic             touch_next_row;
  logic             last_cluster;
  logic             out_last_flag;
  logic             out_neighbour_flag;
  logic             out_event_end_flag;

  modport source (
    output valid, cluster_mask, out_column, out_row, touch_prev_column,
           touch_next_column, touch_prev_row, touch_next_row, last_cluster,
           out_last_flag, out_neighbour_flag, out_event_end_flag,
    input  ready
  );

  modport sink (
    input  valid, cluster_mask, out_column, out_row, touch_prev_column,
           touch_next_column, touch_prev_row, touch_next_row, last_cluster,
           out_last_flag, out_neighbour_flag, out_event_end_flag,
    output ready
  );
endinterface

[rtl/core/qcc_front.sv]
// ---------------------------------------------------------------------------
// Clusterer front end
// Accept a hit mask, form sub-core clusters, merge across halves and push
// the candidate cluster slots into the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module qcc_front (
  qcc_in_if.sink             in_if,
  input  logic               geometry_mode,
  input  qcc_pkg::q_status_t q_stat,
  output logic               push,
  output qcc_pkg::entry_t    push_entry
);
  import qcc_pkg::*;

  // Edge masks for 8x2 and 4x4
  localparam logic [HIT_W-1:0] TPC_M0 = 16'h0003, TPC_M1 = 16'h000F;
  localparam logic [HIT_W-1:0] TNC_M0 = 16'hC000, TNC_M1 = 16'hF000;
  localparam logic [HIT_W-1:0] TPR_M0 = 16'h5555, TPR_M1 = 16'h1111;
  localparam logic [HIT_W-1:0] TNR_M0 = 16'hAAAA, TNR_M1 = 16'h8888;

  logic [HIT_W-1:0]            hits;
  logic [1:0][1:0][HIT_W-1:0]  lst;      // [half][slot]
  logic [1:0][1:0]             lv;
  logic [1:0][HIT_W-1:0]       dil0;
  logic [1:0][1:0]             adj;      // [half-0 slot][half-1 slot]
  logic [1:0]                  pick0, pick1, merged_v;
  logic [1:0][HIT_W-1:0]       merged;

  assign hits = in_if.hit_mask;

  // Accept whenever the queue has room; empty masks are accepted and dropped
  assign in_if.ready = !q_stat.full;
  assign push        = in_if.valid && in_if.ready && (hits != '0);

  // Form clusters in each half, joining a pair whose facing columns both hit
  always_comb begin
    logic [HIT_W-1:0] ma, mb, fa, fb;
    logic             join_pair;
    lst = '0;
    lv  = '0;
    for (int h = 0; h < 2; h++) begin
      ma = hits & (geometry_mode ? sub_bits(2 * h, 1'b1) : sub_bits(2 * h, 1'b0));
      mb = hits & (geometry_mode ? sub_bits(2 * h + 1, 1'b1) : sub_bits(2 * h + 1, 1'b0));
      fa = hits & (geometry_mode ? face_lo(h, 1'b1) : face_lo(h, 1'b0));
      fb = hits & (geometry_mode ? face_hi(h, 1'b1) : face_hi(h, 1'b0));
      join_pair = (fa != '0) && (fb != '0);
      lst[h][0] = join_pair ? (ma | mb) : ma;
      lv[h][0]  = join_pair || (ma != '0);
      lst[h][1] = mb;
      lv[h][1]  = !join_pair && (mb != '0);
    end
  end

  // Merge each half-0 cluster with its first adjacent half-1 cluster
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      dil0[i] = geometry_mode ? dilate(lst[0][i], 1'b1) : dilate(lst[0][i], 1'b0);
      for (int j = 0; j < 2; j++) begin
        adj[i][j] = lv[0][i] && lv[1][j] && ((dil0[i] & lst[1][j]) != '0);
      end
      pick0[i]    = adj[i][0];
      pick1[i]    = !adj[i][0] && adj[i][1];
      merged_v[i] = adj[i][0] || adj[i][1];
      merged[i]   = lst[0][i] | (pick1[i] ? lst[1][1] : lst[1][0]);
    end
  end

  // Build the queue entry in output order
  always_comb begin
    push_entry.mask[0] = merged[0];
    push_entry.mask[1] = merged[1];
    push_entry.mask[2] = lst[0][0];
    push_entry.mask[3] = lst[0][1];
    push_entry.mask[4] = lst[1][0];
    push_entry.mask[5] = lst[1][1];
    push_entry.vld[0]  = merged_v[0];
    push_entry.vld[1]  = merged_v[1];
    push_entry.vld[2]  = lv[0][0] && !merged_v[0];
    push_entry.vld[3]  = lv[0][1] && !merged_v[1];
    push_entry.vld[4]  = lv[1][0] && !(pick0[0] || pick0[1]);
    push_entry.vld[5]  = lv[1][1] && !(pick1[0] || pick1[1]);
    push_entry.column  = in_if.core_column;
    push_entry.row     = in_if.core_row;
    push_entry.touch.prev_column = (hits & (geometry_mode ? TPC_M1 : TPC_M0)) != '0;
    push_entry.touch.next_column = (hits & (geometry_mode ? TNC_M1 : TNC_M0)) != '0;
    push_entry.touch.prev_row    = (hits & (geometry_mode ? TPR_M1 : TPR_M0)) != '0;
    push_entry.touch.next_row    = (hits & (geometry_mode ? TNR_M1 : TNR_M0)) != '0;
    push_entry.last_flag         = in_if.last_flag;
    push_entry.neighbour_flag    = in_if.neighbour_flag;
    push_entry.event_end_flag    = in_if.event_end_flag;
  end

endmodule

[rtl/core/qcc_queue.sv]
// ---------------------------------------------------------------------------
// Clusterer queue
// Short FIFO of classified entries between the front and back ends.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module qcc_queue #(
  parameter int DEPTH = qcc_pkg::QCC_QUEUE_DEPTH   // two or more
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  qcc_pkg::entry_t     push_entry,
  input  logic                pop,
  output qcc_pkg::entry_t     head_entry,
  output qcc_pkg::q_status_t  q_stat
);
  import qcc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             store_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign q_stat.full     = (count_r == CNT_W'(DEPTH));
  assign q_stat.has_data = (count_r != '0);
  assign do_push         = push && !q_stat.full;
  assign do_pop          = pop && q_stat.has_data;
  assign head_entry      = store_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Write the entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

[rtl/core/qcc_back.sv]
// ---------------------------------------------------------------------------
// Clusterer back end
// Walk the valid cluster slots of the current entry and emit one beat per
// cycle while the output is not stalled, through a registered output stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module qcc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  qcc_pkg::q_status_t q_stat,
  input  qcc_pkg::entry_t    head_entry,
  output logic               pop,
  qcc_out_if.source          out_if
);
  import qcc_pkg::*;

  entry_t                cur_r;
  logic [NUM_SLOTS-1:0]  rem_r, rem_nxt;
  logic [NUM_SLOTS-1:0]  pick_oh, rem_after;
  logic [HIT_W-1:0]      sel_mask;
  logic                  load_ok, emit;
  logic                  out_valid_r, out_valid_nxt;
  logic [HIT_W-1:0]      cluster_mask_r;
  entry_t                out_info_r;
  logic                  last_cluster_r;

  // Pick the lowest remaining slot
  always_comb begin
    pick_oh  = '0;
    sel_mask = '0;
    for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
      if (rem_r[k]) begin
        pick_oh    = '0;
        pick_oh[k] = 1'b1;
      end
    end
    for (int k = 0; k < NUM_SLOTS; k++) begin
      sel_mask = sel_mask | (pick_oh[k] ? cur_r.mask[k] : '0);
    end
  end

  assign rem_after = rem_r & ~pick_oh;
  assign load_ok   = !out_valid_r || out_if.ready;
  assign emit      = load_ok && (rem_r != '0);
  assign pop       = q_stat.has_data && ((rem_r == '0) || (emit && (rem_after == '0)));

  // Update remaining slots and output valid
  always_comb begin
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r;
    if (pop) begin
      rem_nxt = head_entry.vld;
    end else if (emit) begin
      rem_nxt = rem_after;
    end
    if (load_ok) begin
      out_valid_nxt = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the current entry and the output beat
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head_entry;
    end
    if (emit) begin
      cluster_mask_r <= sel_mask;
      out_info_r     <= cur_r;
      last_cluster_r <= (rem_after == '0);
    end
  end

  assign out_if.valid              = out_valid_r;
  assign out_if.cluster_mask       = cluster_mask_r;
  assign out_if.out_column         = out_info_r.column;
  assign out_if.out_row            = out_info_r.row;
  assign out_if.touch_prev_column  = out_info_r.touch.prev_column;
  assign out_if.touch_next_column  = out_info_r.touch.next_column;
  assign out_if.touch_prev_row     = out_info_r.touch.prev_row;
  assign out_if.touch_next_row     = out_info_r.touch.next_row;
  assign out_if.last_cluster       = last_cluster_r;
  assign out_if.out_last_flag      = out_info_r.last_flag;
  assign out_if.out_neighbour_flag = out_info_r.neighbour_flag;
  assign out_if.out_event_end_flag = out_info_r.event_end_flag;

endmodule

[rtl/core/quarter_core_pixel_clusterer.sv]
// ---------------------------------------------------------------------------
// Quarter-core pixel clusterer: a hit mask goes through the queue, the back
// end's current entry and the output register; masks are taken while the
// queue has room; the back end emits one cluster per cycle unless stalled.
// Sync reset clears queue, back end, geometry_mode (8x2); no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module quarter_core_pixel_clusterer #(
  parameter int QUEUE_DEPTH = qcc_pkg::QCC_QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  qcc_in_if.sink                          in_if,
  qcc_out_if.source                       out_if,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [qcc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [qcc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [qcc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import qcc_pkg::*;

  logic      geometry_mode_r, geometry_mode_nxt;
  logic      cfg_wr;
  logic      cfg_wr_geom;
  logic      push, pop;
  entry_t    push_entry, head_entry;
  q_status_t q_stat;

  // Configuration register
  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign cfg_wr_geom = cfg_wr && (paddr[2] == REG_IDX_GEOMETRY);
  assign prdata = (paddr[2] == REG_IDX_GEOMETRY) ?
                  {{(APB_DATA_W-1){1'b0}}, geometry_mode_r} : '0;

  always_comb begin
    geometry_mode_nxt = geometry_mode_r;
    if (cfg_wr_geom) begin
      geometry_mode_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geometry_mode_r <= 1'b0;
    end else begin
      geometry_mode_r <= geometry_mode_nxt;
    end
  end

  qcc_front u_front (
    .in_if         (in_if),
    .geometry_mode (geometry_mode_r),
    .q_stat        (q_stat),
    .push          (push),
    .push_entry    (push_entry)
  );

  qcc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_entry (head_entry),
    .q_stat     (q_stat)
  );

  qcc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head_entry (head_entry),
    .pop        (pop),
    .out_if     (out_if)
  );

  // Checks
  `QCC_ASSERT_IMPLY(a_push_nonempty, push, push_entry.vld != '0, "empty entry pushed")
  `QCC_ASSERT_IMPLY(a_full_stalls, q_stat.full, !in_if.ready, "input ready while queue full")
  `QCC_ASSERT_NEXT(a_cfg_write, cfg_wr_geom, geometry_mode_r == $past(pwdata[0]), "write lost")

endmodule
